/* src/ctos_pkg.sv */
// Package with the item types, codes and constants shared by the overlap scan block.
`default_nettype none
package ctos_pkg;

  localparam int unsigned SlotsDefault = 32;
  localparam int unsigned ReportMax    = 32;
  localparam int signed   CoordLimit   = 30000;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SCAN   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_COORD     = 3'd2,
    ST_RADIUS    = 3'd3,
    ST_NOT_ALIVE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_LOADA,
    S_LATCHA,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic [23:0]        radius;
    logic [4:0]         slot_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [31:0] overlap_mask;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [23:0]        r;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_mask;
    logic read_a;
    logic load_a;
    logic issue;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic pipe_busy;
    logic slot_live;
  } stat_t;

endpackage
`default_nettype wire

/* src/ctos_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module ctos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/ctos_ctrl.sv */
// Controller state machine that sequences create, delete and the pairwise scan.
`default_nettype none
module ctos_ctrl import ctos_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [1:0]               in_action_i,
  output logic                          in_stall_o,
  input  wire stat_t                    stat_i,
  output cmd_t                          cmd_o,
  output logic      [$clog2(SLOTS)-1:0] i_idx_o,
  output logic      [$clog2(SLOTS)-1:0] j_idx_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned N  = (SLOTS < ReportMax) ? SLOTS : ReportMax;
  localparam logic [AW-1:0] LastIdx = AW'(N - 1);

  state_e state_q, state_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = !stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (in_action_i == ACT_SCAN) begin
            cmd_o.clear_mask = 1'b1;
            i_d              = '0;
            state_d          = S_PICK;
          end
        end
      end
      S_PICK: begin
        // A dead slot reports an empty mask without touching the store.
        state_d = stat_i.slot_live ? S_LOADA : S_EMIT;
      end
      S_LOADA: begin
        cmd_o.read_a = 1'b1;
        state_d      = S_LATCHA;
      end
      S_LATCHA: begin
        cmd_o.load_a = 1'b1;
        j_d          = '0;
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        j_d         = AW'(j_q + 1'b1);
        if (j_q == LastIdx) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (i_q == LastIdx) begin
            state_d = S_IDLE;
          end else begin
            i_d     = AW'(i_q + 1'b1);
            state_d = S_PICK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign i_idx_o = i_q;
  assign j_idx_o = j_q;

endmodule
`default_nettype wire

/* src/ctos_dp.sv */
// Datapath: live flags, circle store, overlap test pipeline and output register.
`default_nettype none
module ctos_dp import ctos_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire in_item_t                 in_item_i,
  input  wire cmd_t                     cmd_i,
  input  wire logic [$clog2(SLOTS)-1:0] i_idx_i,
  input  wire logic [$clog2(SLOTS)-1:0] j_idx_i,
  output stat_t                         stat_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output out_item_t                     out_item_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned N  = (SLOTS < ReportMax) ? SLOTS : ReportMax;
  localparam int unsigned NW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned EW = $bits(entry_t);
  localparam logic [AW-1:0] LastIdx = AW'(N - 1);

  logic [SLOTS-1:0] live_q, live_d;
  logic [N-1:0]     mask_q, mask_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  // Lowest free slot.
  logic          free_found;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!live_q[k]) begin
        free_found = 1'b1;
        free_idx   = AW'(k);
      end
    end
  end

  // Delete hits only a live slot below the slot count.
  logic del_hit;
  always_comb begin
    del_hit = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if (k < 32 && live_q[k] && in_item_i.slot_id == 5'(k)) begin
        del_hit = 1'b1;
      end
    end
  end

  logic coord_bad;
  assign coord_bad = (in_item_i.centre_x > 16'(CoordLimit))
                  || (in_item_i.centre_x < -16'(CoordLimit))
                  || (in_item_i.centre_y > 16'(CoordLimit))
                  || (in_item_i.centre_y < -16'(CoordLimit));

  logic is_create, is_delete, create_ok;
  assign is_create = cmd_i.accept && (in_item_i.action == ACT_CREATE);
  assign is_delete = cmd_i.accept && (in_item_i.action == ACT_DELETE);
  assign create_ok = is_create && free_found && !coord_bad && (in_item_i.radius != '0);

  // Circle store.
  entry_t  wr_entry, rd_entry;
  logic [EW-1:0] rd_raw;
  assign wr_entry.x = in_item_i.centre_x;
  assign wr_entry.y = in_item_i.centre_y;
  assign wr_entry.r = in_item_i.radius;

  ctos_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (create_ok),
    .waddr_i (free_idx),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.read_a || cmd_i.issue),
    .raddr_i (cmd_i.read_a ? i_idx_i : j_idx_i),
    .rdata_o (rd_raw)
  );
  assign rd_entry = entry_t'(rd_raw);

  entry_t a_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      a_q <= rd_entry;
    end
  end

  // Pair test pipeline: read, difference, square, compare.
  logic          v0_q, v1_q, v2_q;
  logic          h0_q, h1_q, h2_q;
  logic [AW-1:0] j0_q, j1_q, j2_q;
  logic [24:0]   rs1_q;
  logic [15:0]   adx1_q, ady1_q;
  logic [49:0]   rs2_q;
  logic [31:0]   dx2_q, dy2_q;

  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  assign dx  = 17'(a_q.x) - 17'(rd_entry.x);
  assign dy  = 17'(a_q.y) - 17'(rd_entry.y);
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);

  logic        hit_in;
  assign hit_in = live_q[j_idx_i] && (j_idx_i != i_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h0_q   <= hit_in;
    j0_q   <= j_idx_i;
    h1_q   <= h0_q;
    j1_q   <= j0_q;
    rs1_q  <= {1'b0, a_q.r} + {1'b0, rd_entry.r};
    adx1_q <= adx[15:0];
    ady1_q <= ady[15:0];
    h2_q   <= h1_q;
    j2_q   <= j1_q;
    rs2_q  <= rs1_q * rs1_q;
    dx2_q  <= adx1_q * adx1_q;
    dy2_q  <= ady1_q * ady1_q;
  end

  logic [32:0] dist2;
  logic        touch;
  assign dist2 = {1'b0, dx2_q} + {1'b0, dy2_q};
  // Centres are integers and the radius has 8 fraction bits, so squared distance scales by 2^16.
  assign touch = rs2_q >= {1'b0, dist2, 16'b0};

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.clear_mask || cmd_i.emit) begin
      mask_d = '0;
    end else if (v2_q && h2_q) begin
      mask_d[j2_q[NW-1:0]] = touch;
    end
  end

  always_comb begin
    live_d = live_q;
    if (create_ok) begin
      live_d[free_idx] = 1'b1;
    end
    if (is_delete && del_hit) begin
      live_d[AW'(in_item_i.slot_id)] = 1'b0;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (is_create) begin
      out_valid_d        = 1'b1;
      out_d.slot         = '0;
      out_d.overlap_mask = '0;
      out_d.last         = 1'b1;
      priority if (!free_found) begin
        out_d.status = ST_FULL;
      end else if (coord_bad) begin
        out_d.status = ST_COORD;
      end else if (in_item_i.radius == '0) begin
        out_d.status = ST_RADIUS;
      end else begin
        out_d.status = ST_OK;
        out_d.slot   = 5'(free_idx);
      end
    end else if (is_delete) begin
      out_valid_d        = 1'b1;
      out_d.status       = del_hit ? ST_OK : ST_NOT_ALIVE;
      out_d.slot         = in_item_i.slot_id;
      out_d.overlap_mask = '0;
      out_d.last         = 1'b1;
    end else if (cmd_i.emit) begin
      out_valid_d        = 1'b1;
      out_d.status       = ST_OK;
      out_d.slot         = 5'(i_idx_i);
      out_d.overlap_mask = 32'(mask_q);
      out_d.last         = (i_idx_i == LastIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    out_q  <= out_d;
  end

  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.pipe_busy = v0_q || v1_q || v2_q;
  assign stat_o.slot_live = live_q[i_idx_i];
  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;

endmodule
`default_nettype wire

/* src/circle_table_overlap_scan_top.sv */
// Top level of the circle table overlap scan block.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------
//   in      | input     | in_valid_i/in_stall_o   | in_item_i (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// Create and delete give one item each through the output register.
// A scan covers N reported slots: each live slot loads its own circle, then streams
// every slot through one store read port into a three stage difference, square and
// compare pipeline.
// A dead slot skips to emit. Reset clears the live flags; the store needs no clear.
// A stalled output holds the scan in place; input is taken only between items.
`default_nettype none
module circle_table_overlap_scan_top import ctos_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  cmd_t  cmd;
  stat_t stat;
  logic [$clog2(SLOTS)-1:0] i_idx, j_idx;

  ctos_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .i_idx_o     (i_idx),
    .j_idx_o     (j_idx)
  );

  ctos_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .i_idx_i     (i_idx),
    .j_idx_i     (j_idx),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A scan result is only written into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> stat.out_free)
    else $error("scan result written over a pending item");

  // The mask is complete before it is emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> !stat.pipe_busy)
    else $error("scan result emitted with pair tests in flight");

  // No new item enters while pair tests are still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.accept |-> !stat.pipe_busy)
    else $error("item accepted during a scan");

endmodule
`default_nettype wire

/* bench/ctos_checker.sv */
// Checker that predicts and compares the circle table overlap scan output items.
`timescale 1ns / 1ps
module ctos_checker import ctos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic               live [32];
  logic signed [15:0] cx [32];
  logic signed [15:0] cy [32];
  logic [23:0]        cr [32];
  out_item_t          expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic circles_touch(int a, int b);
    logic [63:0] rs, dx, dy;
    rs = 64'(cr[a]) + 64'(cr[b]);
    dx = 64'(longint'(cx[a]) - longint'(cx[b])) * 256;
    dy = 64'(longint'(cy[a]) - longint'(cy[b])) * 256;
    return rs * rs >= dx * dx + dy * dy;
  endfunction

  task automatic predict_item(in_item_t it);
    out_item_t o;
    int freeslot;
    freeslot = -1;
    o = '0;
    o.last = 1'b1;
    case (action_e'(it.action))
      ACT_CREATE: begin
        for (int i = 31; i >= 0; i--) if (!live[i]) freeslot = i;
        if (freeslot < 0) o.status = ST_FULL;
        else if (it.centre_x > CoordLimit || it.centre_x < -CoordLimit ||
                 it.centre_y > CoordLimit || it.centre_y < -CoordLimit)
          o.status = ST_COORD;
        else if (it.radius == 0) o.status = ST_RADIUS;
        else begin
          o.status = ST_OK;
          o.slot = 5'(freeslot);
          live[freeslot] = 1'b1;
          cx[freeslot] = it.centre_x;
          cy[freeslot] = it.centre_y;
          cr[freeslot] = it.radius;
        end
        expected_q.push_back(o);
      end
      ACT_DELETE: begin
        o.slot = it.slot_id;
        if (live[it.slot_id]) begin
          o.status = ST_OK;
          live[it.slot_id] = 1'b0;
        end else o.status = ST_NOT_ALIVE;
        expected_q.push_back(o);
      end
      ACT_SCAN: begin
        for (int i = 0; i < 32; i++) begin
          o = '0;
          o.status = ST_OK;
          o.slot = 5'(i);
          o.last = (i == 31);
          if (live[i])
            for (int j = 0; j < 32; j++)
              if (j != i && live[j] && circles_touch(i, j)) o.overlap_mask[j] = 1'b1;
          expected_q.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_q.delete();
      for (int i = 0; i < 32; i++) live[i] = 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected output item %p", out_item_i);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_item_i.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_item_i.status);
            errs++;
          end
          if (out_item_i.slot !== e.slot) begin
            $error("slot: expected %0d actual %0d", e.slot, out_item_i.slot);
            errs++;
          end
          if (out_item_i.overlap_mask !== e.overlap_mask) begin
            $error("overlap_mask: expected %h actual %h", e.overlap_mask,
                   out_item_i.overlap_mask);
            errs++;
          end
          if (out_item_i.last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_item_i.last);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (in_valid_i && !in_stall_i) predict_item(in_item_i);
    end
  end

endmodule

/* bench/tb.sv */
// Testbench top: stimulus, idling, watchdog and verdict for the overlap scan block.
`timescale 1ns / 1ps
module tb import ctos_pkg::*;;

  localparam int WatchdogLimit = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count, pending;
  int        idle_cycles = 0;
  bit        calm = 1'b0;
  bit        hold_off = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  circle_table_overlap_scan_top u_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_item_i(in_item), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_item_o(out_item)
  );

  ctos_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_item_i(in_item), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_item_i(out_item), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall; a long hold-off fills the block so its input stalls.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 32);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Valid stays high after an item is taken so the next item can follow at once;
  // idling or draining drops it.
  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord(bit near);
    case ($urandom_range(9))
      0: return 16'($urandom());
      1: return $urandom_range(1) ? 16'sd30000 : -16'sd30000;
      2: return $urandom_range(1) ? 16'sd30001 : -16'sd30001;
      default:
        return near ? 16'(int'($urandom_range(400)) - 200)
                    : 16'(int'($urandom_range(60000)) - 30000);
    endcase
  endfunction

  task automatic send_create(logic signed [15:0] x, logic signed [15:0] y,
                             logic [23:0] r);
    in_item_t it;
    it = in_item_t'(63'({$urandom(), $urandom()}));
    it.action = ACT_CREATE;
    it.centre_x = x;
    it.centre_y = y;
    it.radius = r;
    send_item(it);
  endtask

  task automatic send_simple(action_e a, logic [4:0] id);
    in_item_t it;
    it = in_item_t'(63'({$urandom(), $urandom()}));
    it.action = a;
    it.slot_id = id;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: rejects, extremes, touching and exact tangency.
    send_simple(ACT_DELETE, 5'd0);
    send_simple(ACT_SCAN, 5'd0);
    send_create(16'sd30001, 16'sd0, 24'd256);
    send_create(16'sd0, -16'sd30001, 24'd256);
    send_create(-16'sd32768, 16'sd32767, 24'd256);
    send_create(16'sd0, 16'sd0, 24'd0);
    send_create(16'sd30000, -16'sd30000, 24'hFFFFFF);
    send_create(-16'sd30000, 16'sd30000, 24'hFFFFFF);
    send_create(16'sd0, 16'sd0, 24'd256);
    send_create(16'sd2, 16'sd0, 24'd256);
    send_create(16'sd5, 16'sd0, 24'd256);
    send_create(16'sd0, 16'sd3, 24'd1);
    send_simple(ACT_SCAN, 5'd0);
    send_simple(ACT_NONE, 5'd3);
    send_simple(ACT_DELETE, 5'd1);
    send_simple(ACT_DELETE, 5'd1);
    send_simple(ACT_DELETE, 5'd31);
    send_simple(ACT_SCAN, 5'd0);
    for (int i = 0; i < 30; i++) send_create(16'(i * 3), 16'sd0, 24'd300);
    send_create(16'sd0, 16'sd0, 24'd1);
    send_simple(ACT_SCAN, 5'd0);
    send_simple(ACT_DELETE, 5'd31);

    // Receiver holds off while the sender keeps offering items.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        send_simple(ACT_SCAN, 5'd0);
        send_simple(ACT_DELETE, 5'd4);
        send_simple(ACT_DELETE, 5'd9);
      end
    join
    drain_results();

    // Random part, mostly creates and deletes that keep the table churning.
    n = 0;
    while (n < 320) begin
      calm = (n >= 120 && n < 170);
      case ($urandom_range(19))
        0: send_simple(ACT_SCAN, 5'($urandom()));
        1: send_simple(ACT_NONE, 5'($urandom()));
        2, 3, 4, 5, 6, 7, 8, 9: begin
          send_simple(ACT_DELETE, 5'($urandom()));
          n++;
        end
        default: begin
          send_create(pick_coord(1'b1), pick_coord(1'b1),
                      ($urandom_range(15) == 0) ? 24'($urandom_range(1))
                                                : 24'($urandom_range(1, 90000)));
          n++;
        end
      endcase
      if (n == 200) drain_results();
    end
    calm = 1'b0;
    send_simple(ACT_SCAN, 5'd0);
    send_simple(ACT_SCAN, 5'd0);

    drain_results();
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
